### hw/rtl/csb_pkg.sv
// Shared constants, request codes and result type of the counting semaphore bank.
`default_nettype none

package csb_pkg;

  // Default sizes of the bank.
  localparam int unsigned NUM_RESOURCES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned PID_BITS_DEF      = 16;

  // Fixed field widths of the request and result words.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned RES_FLD_W = 4;
  localparam int unsigned PID_FLD_W = 16;
  localparam int unsigned COUNT_W   = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  // Request codes carried in in_tuser.
  localparam logic [KIND_W-1:0] REQ_INIT   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_WAIT   = 2'd1;
  localparam logic [KIND_W-1:0] REQ_SIGNAL = 2'd2;

  typedef struct packed {
    logic [PID_FLD_W-1:0] woken_pid;
    logic                 overflow;
    logic                 blocked;
    logic                 granted;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/csb_ctl_mem.sv
// Per-resource control memory (count, queue head, queue fill) with reset-to-zero valid bits.
`default_nettype none

module csb_ctl_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned WIDTH = 26
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] q_r;
  logic             q_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as all zero.
  assign rd_data = q_valid_r ? q_r : '0;

endmodule

`default_nettype wire

### hw/rtl/csb_slot_mem.sv
// Wait-queue slot memory holding the blocked pids of every resource.
`default_nettype none

module csb_slot_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/counting_semaphore_bank_top.sv
// Top level of the counting semaphore bank: request sequencer, memories and result register.
//
// A bank of counting semaphores, each with a FIFO of blocked process ids.
// Requests arrive on the in_ stream; the request kind (init, wait, signal)
// travels in in_tuser and the resource, pid and permit count in in_tdata.
// Every accepted word yields exactly one result word on the out_ stream:
// granted, blocked, overflow and the pid woken by a signal.
//
// Per-resource count, queue head and queue fill live in a small control
// memory; the queued pids live in a slot memory of NUM_RESOURCES times
// QUEUE_DEPTH entries. Both have registered reads. The control entry
// is read at the accepting edge, resolved in the following cycle and written
// back once the output register is free; a signal that pops a waiter first
// reads the oldest pid from the slot memory in state S_SLOT. A new word is
// taken in the cycle after write-back, so the bank does not accept a word
// until the previous one has been written back.
//
// Reset (rst_n low, synchronous) clears all counts, heads and fills through
// per-entry valid bits at once. A finished result waits in the output register
// while the next word is accepted and read; that word is held before
// write-back until the receiver takes the pending result.
`default_nettype none

module counting_semaphore_bank_top #(
  parameter int unsigned NUM_RESOURCES = csb_pkg::NUM_RESOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH   = csb_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PID_BITS      = csb_pkg::PID_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_tdata: resource[3:0], pid[19:4], permits[35:20], zero pad[39:36]
  input  wire logic [csb_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: req_type[1:0]
  input  wire logic [csb_pkg::KIND_W-1:0]         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_tdata: granted[0], blocked[1], overflow[2], woken_pid[18:3], zero pad[23:19]
  output logic [csb_pkg::OUT_DATA_W-1:0]          out_tdata
);

  import csb_pkg::*;

  // Derived sizes.
  localparam int unsigned RES_W      = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
  localparam int unsigned QH_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QF_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TS_W       = QF_W + 1;
  localparam int unsigned CTL_W      = COUNT_W + QH_W + QF_W;
  localparam int unsigned SLOT_DEPTH = NUM_RESOURCES * QUEUE_DEPTH;
  localparam int unsigned SA_W       = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int unsigned SLOT_W     = (PID_BITS < PID_FLD_W) ? PID_BITS : PID_FLD_W;
  localparam int unsigned RNG_W      = 9;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CTL  = 3'b010,
    S_SLOT = 3'b100
  } state_t;

  // Request fields.
  logic [RES_FLD_W-1:0] in_resource;
  logic [PID_FLD_W-1:0] in_pid;
  logic [COUNT_W-1:0]   in_permits;
  logic [RES_W-1:0]     in_res_idx;
  logic                 in_accept;

  assign in_resource = in_tdata[3:0];
  assign in_pid      = in_tdata[19:4];
  assign in_permits  = in_tdata[35:20];
  assign in_res_idx  = RES_W'(in_resource);

  // Request registers.
  state_t             state_r, state_nxt;
  logic [KIND_W-1:0]  kind_r;
  logic [RES_W-1:0]   res_idx_r;
  logic               in_range_r;
  logic [SLOT_W-1:0]  pid_r;
  logic [COUNT_W-1:0] permits_r;
  logic [SA_W-1:0]    base_r;

  // Result register.
  logic out_tvalid_r;
  res_t res_r, res_nxt;

  // Memory ports.
  logic [CTL_W-1:0]  ctl_rd_data, ctl_wr_data;
  logic              ctl_wr_en;
  logic              slot_rd_en, slot_wr_en;
  logic [SA_W-1:0]   slot_rd_addr, slot_wr_addr;
  logic [SLOT_W-1:0] slot_rd_data;

  // Decoded control entry.
  logic [COUNT_W-1:0] cnt;
  logic [QH_W-1:0]    head;
  logic [QF_W-1:0]    fill;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [QH_W-1:0]    head_nxt;
  logic [QF_W-1:0]    fill_nxt;
  logic [QH_W-1:0]    head_inc;
  logic [TS_W-1:0]    tail_sum;
  logic [QH_W-1:0]    tail;
  logic               pop_needed;
  logic               out_free;
  logic               commit;

  assign {cnt, head, fill} = ctl_rd_data;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;

  // A signal with waiters queued needs the oldest pid from the slot memory.
  assign pop_needed = in_range_r && (kind_r == REQ_SIGNAL) && (fill != '0);

  assign commit = ((state_r == S_CTL) && !pop_needed && out_free) ||
                  ((state_r == S_SLOT) && out_free);

  // Queue pointer arithmetic; head and fill are always in range, so one
  // conditional subtract wraps the tail.
  assign head_inc = (head == QH_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_sum = TS_W'(head) + TS_W'(fill);
  assign tail     = (tail_sum >= TS_W'(QUEUE_DEPTH)) ?
                    QH_W'(tail_sum - TS_W'(QUEUE_DEPTH)) : QH_W'(tail_sum);

  always_comb begin
    cnt_nxt    = cnt;
    head_nxt   = head;
    fill_nxt   = fill;
    res_nxt    = '0;
    slot_wr_en = 1'b0;
    if (in_range_r) begin
      case (kind_r)
        REQ_INIT: begin
          cnt_nxt = permits_r;
        end
        REQ_WAIT: begin
          if (cnt != '0) begin
            cnt_nxt         = cnt - 1'b1;
            res_nxt.granted = 1'b1;
          end else if (fill >= QF_W'(QUEUE_DEPTH)) begin
            res_nxt.overflow = 1'b1;
          end else begin
            fill_nxt        = fill + 1'b1;
            slot_wr_en      = commit;
            res_nxt.blocked = 1'b1;
          end
        end
        REQ_SIGNAL: begin
          if (fill != '0) begin
            head_nxt          = head_inc;
            fill_nxt          = fill - 1'b1;
            res_nxt.woken_pid = PID_FLD_W'(slot_rd_data);
          end else if (cnt == COUNT_MAX) begin
            res_nxt.overflow = 1'b1;
          end else begin
            cnt_nxt = cnt + 1'b1;
          end
        end
        default: begin
          // Unknown request kind: no state change, all-zero result.
        end
      endcase
    end
  end

  assign ctl_wr_en    = commit && in_range_r;
  assign ctl_wr_data  = {cnt_nxt, head_nxt, fill_nxt};
  assign slot_wr_addr = base_r + SA_W'(tail);
  assign slot_rd_en   = (state_r == S_CTL) && pop_needed;
  assign slot_rd_addr = base_r + SA_W'(head);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CTL;
        end
      end
      S_CTL: begin
        if (pop_needed) begin
          state_nxt = S_SLOT;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SLOT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r     <= in_tuser;
      res_idx_r  <= in_res_idx;
      in_range_r <= (RNG_W'(in_resource) < RNG_W'(NUM_RESOURCES));
      pid_r      <= SLOT_W'(in_pid);
      permits_r  <= in_permits;
      base_r     <= SA_W'(in_res_idx * QUEUE_DEPTH);
    end
    if (commit) begin
      res_r <= res_nxt;
    end
  end

  csb_ctl_mem #(
    .DEPTH (NUM_RESOURCES),
    .AW    (RES_W),
    .WIDTH (CTL_W)
  ) u_ctl_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_res_idx),
    .rd_data (ctl_rd_data),
    .wr_en   (ctl_wr_en),
    .wr_addr (res_idx_r),
    .wr_data (ctl_wr_data)
  );

  csb_slot_mem #(
    .DEPTH (SLOT_DEPTH),
    .AW    (SA_W),
    .WIDTH (SLOT_W)
  ) u_slot_mem (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (pid_r)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

  // A result word never carries more than one of the three status flags.
  a_one_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($countones({res_r.granted, res_r.blocked, res_r.overflow}) <= 1))
    else $error("more than one status flag in a result word");

  // A woken pid is reported only by a signal that popped a waiter.
  a_woken_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_r.woken_pid != '0)) |->
      (!res_r.granted && !res_r.blocked && !res_r.overflow))
    else $error("woken pid reported together with a status flag");

  // The write-back never pushes a queue past its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_wr_en |-> (fill_nxt <= QF_W'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  // A pending result is never overwritten before the receiver takes it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(res_r))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
